// ===== design/block_peak_normalize_dac_requant_core_macros.svh =====
// Assertion macros shared by the checker of the block peak normalizer.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef BLOCK_PEAK_NORMALIZE_DAC_REQUANT_CORE_MACROS_SVH
`define BLOCK_PEAK_NORMALIZE_DAC_REQUANT_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BPNDR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define BPNDR_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== design/bpndr_pkg.sv =====
// Package of the block peak normalizer: widths, reset values, register
// indexes, the controller state type, gain unit structs and the requantizer.
package bpndr_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int PEAK_W        = SAMPLE_W + 1;
  localparam int CODE_W        = 10;
  localparam int OUT_TDATA_W   = 16;
  localparam int CFG_W         = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int GAIN_W        = 4;
  localparam int BLOCK_SIZE_DEF = 64;

  localparam logic [CFG_W-1:0] MAX_GAIN_RST = 4'd10;
  localparam logic [CFG_W-1:0] OUT_BITS_RST = 4'd10;

  // Full scale is 32768; any peak at or below full scale / 16 gives a
  // quotient of at least 16, which is above every possible gain limit.
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'h8000;
  localparam logic [PEAK_W-1:0]   SAT_PEAK   = PEAK_W'(32768 / 16);

  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_BITS = 2'd1;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [PEAK_W-1:0] peak;
    logic [GAIN_W-1:0] cap;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] gain;
  } div_rsp_t;

  // Scale one sample by the gain, saturate to 16 bits, shift into offset
  // binary less 512, 256 or 128 (for 10, 9 or 8 bits), clamp at zero and keep the top bits.
  function automatic logic [CODE_W-1:0] requant(input logic signed [SAMPLE_W-1:0] s,
                                                input logic [GAIN_W-1:0] gain,
                                                input logic [CFG_W-1:0] bits);
    logic signed [SAMPLE_W+GAIN_W:0] prod;
    logic [SAMPLE_W-1:0] sat;
    logic [SAMPLE_W-1:0] biased;
    logic [SAMPLE_W-1:0] offset;
    logic [SAMPLE_W-1:0] j;
    logic [CODE_W-1:0] code;
    prod = s * $signed({1'b0, gain});
    if (prod > $signed((SAMPLE_W+GAIN_W+1)'(32767))) begin
      sat = 16'h7FFF;
    end else if (prod < -$signed((SAMPLE_W+GAIN_W+1)'(32768))) begin
      sat = 16'h8000;
    end else begin
      sat = prod[SAMPLE_W-1:0];
    end
    biased = {~sat[SAMPLE_W-1], sat[SAMPLE_W-2:0]};
    if (bits inside {[4'd10:4'd15]}) begin
      offset = 16'd512;
    end else if (bits == 4'd9) begin
      offset = 16'd256;
    end else begin
      offset = 16'd128;
    end
    j = (biased >= offset) ? (biased - offset) : '0;
    if (bits inside {[4'd10:4'd15]}) begin
      code = j[15:6];
    end else if (bits == 4'd9) begin
      code = {1'b0, j[15:7]};
    end else begin
      code = {2'b00, j[15:8]};
    end
    return code;
  endfunction

endpackage

// ===== design/bpndr_mem.sv =====
// Sample store of the block peak normalizer: one write port, one read port,
// read data registered. Uses no package items.
module bpndr_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/bpndr_gain_div.sv =====
// Gain unit of the block peak normalizer: restoring division of full scale
// by the block peak, one quotient bit per cycle, capped. Uses bpndr_pkg.
module bpndr_gain_div (
  input  logic                clk,
  input  logic                rst_n,
  input  bpndr_pkg::div_req_t req,
  output bpndr_pkg::div_rsp_t rsp
);

  localparam int TRIAL_W = bpndr_pkg::PEAK_W + 3;

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [1:0]                        step_r, step_nxt;
  logic [bpndr_pkg::SAMPLE_W-1:0]    rem_r, rem_nxt;
  logic [bpndr_pkg::PEAK_W-1:0]      peak_r, peak_nxt;
  logic [bpndr_pkg::GAIN_W-1:0]      quo_r, quo_nxt;
  logic [bpndr_pkg::GAIN_W-1:0]      gain_r, gain_nxt;
  logic                              sat_r, sat_nxt;
  logic [TRIAL_W-1:0]                trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    peak_r <= peak_nxt;
    quo_r  <= quo_nxt;
    gain_r <= gain_nxt;
    sat_r  <= sat_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    peak_nxt = peak_r;
    quo_nxt  = quo_r;
    gain_nxt = gain_r;
    sat_nxt  = sat_r;
    trial    = TRIAL_W'(peak_r) << step_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd3;
      rem_nxt  = bpndr_pkg::FULL_SCALE;
      peak_nxt = req.peak;
      quo_nxt  = '0;
      sat_nxt  = (req.peak <= bpndr_pkg::SAT_PEAK);
    end else if (busy_r) begin
      if (TRIAL_W'(rem_r) >= trial) begin
        rem_nxt         = rem_r - trial[bpndr_pkg::SAMPLE_W-1:0];
        quo_nxt[step_r] = 1'b1;
      end
      step_nxt = step_r - 2'd1;
      if (step_r == 2'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        // A silent block also lands here, since zero is below the limit.
        gain_nxt = (sat_r || (quo_nxt > req.cap)) ? req.cap : quo_nxt;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.gain = gain_r;

endmodule

// ===== design/block_peak_normalize_dac_requant_core.sv =====
// A block closes on the request marked last or on its BLOCK_SIZE-th request.
// Samples are taken one a cycle while a block fills; codes then leave with
// one read of the sample store in flight at a time (read of the sample store,
// then output register), so a new read waits until the last one is loaded.
// Sync active-low reset clears control, peak, fill count and config; the
// sample store is not cleared.
module block_peak_normalize_dac_requant_core #(
  parameter int BLOCK_SIZE = bpndr_pkg::BLOCK_SIZE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream. tdata: sample [15:0]. tlast: last.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bpndr_pkg::SAMPLE_W-1:0]       in_tdata,
  input  logic                                 in_tlast,
  // Result stream. tdata: code [9:0], zeros [15:10]. tlast: end_of_block.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bpndr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                 out_tlast,
  // Configuration writes: index 0 is max_gain, index 1 is out_bits.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bpndr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpndr_pkg::CFG_W-1:0]          cfg_data
);

  localparam int ADDR_W = $clog2(BLOCK_SIZE);
  localparam int CNT_W  = $clog2(BLOCK_SIZE + 1);

  bpndr_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]                  fill_r, fill_nxt;
  logic [CNT_W-1:0]                  emit_cnt_r, emit_cnt_nxt;
  logic [bpndr_pkg::PEAK_W-1:0]      peak_r, peak_nxt;
  logic [ADDR_W-1:0]                 rd_idx_r, rd_idx_nxt;
  logic                              rd_pend_r, rd_pend_nxt;
  logic                              rd_last_r, rd_last_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [bpndr_pkg::CODE_W-1:0]      code_r, code_nxt;
  logic                              eob_r, eob_nxt;
  logic [bpndr_pkg::CFG_W-1:0]       max_gain_r;
  logic [bpndr_pkg::CFG_W-1:0]       out_bits_r;

  logic                              in_acc;
  logic [bpndr_pkg::PEAK_W-1:0]      mag;
  logic [bpndr_pkg::PEAK_W-1:0]      peak_upd;
  logic [CNT_W-1:0]                  fill_inc;
  logic                              close_blk;
  logic                              out_free;
  logic                              rd_is_last;
  logic                              mem_wr;
  logic                              mem_rd;
  logic [bpndr_pkg::SAMPLE_W-1:0]    rd_data;

  bpndr_pkg::div_req_t div_req;
  bpndr_pkg::div_rsp_t div_rsp;

  // Configuration is always taken; the user must change it only while the block is idle; the block does not check.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gain_r <= bpndr_pkg::MAX_GAIN_RST;
      out_bits_r <= bpndr_pkg::OUT_BITS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bpndr_pkg::REG_MAX_GAIN: max_gain_r <= cfg_data;
        bpndr_pkg::REG_OUT_BITS: out_bits_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpndr_pkg::ST_COLLECT;
      fill_r      <= '0;
      peak_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      peak_r      <= peak_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emit_cnt_r <= emit_cnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_last_r  <= rd_last_nxt;
    code_r     <= code_nxt;
    eob_r      <= eob_nxt;
  end

  // Magnitude is one bit wider than a sample so that -32768 stays unsigned.
  assign in_acc   = in_tvalid && in_tready;
  assign mag      = in_tdata[bpndr_pkg::SAMPLE_W-1]
                    ? ({1'b0, ~in_tdata} + bpndr_pkg::PEAK_W'(1))
                    : {1'b0, in_tdata};
  assign peak_upd = (mag > peak_r) ? mag : peak_r;
  assign fill_inc = fill_r + 1'b1;
  // A block closes on last, or by itself once the store is full.
  assign close_blk = in_tlast || (fill_inc == CNT_W'(BLOCK_SIZE));
  // The output register can take a new code in the cycle after a read if it
  // is empty now or its code is being taken now.
  assign out_free   = !out_valid_r || out_tready;
  assign rd_is_last = ((CNT_W'(rd_idx_r) + 1'b1) == emit_cnt_r);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    peak_nxt      = peak_r;
    emit_cnt_nxt  = emit_cnt_r;
    rd_idx_nxt    = rd_idx_r;
    rd_pend_nxt   = 1'b0;
    rd_last_nxt   = rd_last_r;
    in_tready     = 1'b0;
    mem_wr        = 1'b0;
    mem_rd        = 1'b0;
    div_req.start = 1'b0;
    div_req.peak  = peak_upd;
    div_req.cap   = (max_gain_r == '0) ? bpndr_pkg::GAIN_W'(1) : max_gain_r;

    case (state_r)
      bpndr_pkg::ST_COLLECT: begin
        in_tready = 1'b1;
        if (in_acc) begin
          mem_wr = 1'b1;
          if (close_blk) begin
            fill_nxt      = '0;
            peak_nxt      = '0;
            emit_cnt_nxt  = fill_inc;
            div_req.start = 1'b1;
            state_nxt     = bpndr_pkg::ST_DIV;
          end else begin
            fill_nxt = fill_inc;
            peak_nxt = peak_upd;
          end
        end
      end
      bpndr_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          rd_idx_nxt = '0;
          state_nxt  = bpndr_pkg::ST_EMIT;
        end
      end
      bpndr_pkg::ST_EMIT: begin
        // One read in flight at a time; the last read hands control back to
        // collection while its code is still on the way out.
        if (!rd_pend_r && out_free) begin
          mem_rd      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_last_nxt = rd_is_last;
          rd_idx_nxt  = rd_idx_r + 1'b1;
          if (rd_is_last) begin
            state_nxt = bpndr_pkg::ST_COLLECT;
          end
        end
      end
      default: begin
        state_nxt = bpndr_pkg::ST_COLLECT;
      end
    endcase
  end

  // Output register: loaded from the sample just read, scaled by the gain.
  always_comb begin
    out_valid_nxt = out_valid_r;
    code_nxt      = code_r;
    eob_nxt       = eob_r;
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      code_nxt      = bpndr_pkg::requant(rd_data, div_rsp.gain, out_bits_r);
      eob_nxt       = rd_last_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bpndr_pkg::OUT_TDATA_W - bpndr_pkg::CODE_W){1'b0}}, code_r};
  assign out_tlast  = eob_r;

  bpndr_mem #(
    .DEPTH  (BLOCK_SIZE),
    .ADDR_W (ADDR_W),
    .DATA_W (bpndr_pkg::SAMPLE_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data (in_tdata),
    .rd_en   (mem_rd),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  bpndr_gain_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

// ===== design/bpndr_checker.sv =====
// Port-level checker of the block peak normalizer, bound to the top level.
// Depends on block_peak_normalize_dac_requant_core_macros.svh and bpndr_pkg.
`include "block_peak_normalize_dac_requant_core_macros.svh"

module bpndr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [bpndr_pkg::SAMPLE_W-1:0]    in_tdata,
  input logic                              in_tlast,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [bpndr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tlast,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [bpndr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [bpndr_pkg::CFG_W-1:0]       cfg_data
);

  // A stalled code must not change.
  `BPNDR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")

  // The pad bits above the code are always zero.
  `BPNDR_ASSERT(a_out_pad, !out_tvalid || (out_tdata[bpndr_pkg::OUT_TDATA_W-1:bpndr_pkg::CODE_W] == '0), "pad bits of the code are set")

  // A sample marked last closes the block, so the next sample must wait.
  `BPNDR_ASSERT_NEXT(a_close_stalls, in_tvalid && in_tready && in_tlast, !in_tready, "input taken right after a closing sample")

  // Configuration writes are never refused.
  `BPNDR_ASSERT(a_cfg_ready, cfg_ready, "configuration write refused")

endmodule

bind block_peak_normalize_dac_requant_core bpndr_checker u_bpndr_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for block_peak_normalize_dac_requant_core.
// Needs only bpndr_pkg and the core; a block-level predictor in this file computes the codes.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W    = bpndr_pkg::SAMPLE_W;
  localparam int CODE_W      = bpndr_pkg::CODE_W;
  localparam int OUT_TDATA_W = bpndr_pkg::OUT_TDATA_W;
  localparam int CFG_W       = bpndr_pkg::CFG_W;
  localparam int CFG_IDX_W   = bpndr_pkg::CFG_IDX_W;

  localparam int BLOCK_LEN   = bpndr_pkg::BLOCK_SIZE_DEF;
  // Idle cycles after the last code before the core is treated as back in collect.
  localparam int SETTLE      = 16;
  // Cycles without any accepted request before the run is declared hung.
  localparam int STUCK_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 60;

  // One predicted DAC word: the code and the end-of-block marker.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              eob;
  } dac_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [SAMPLE_W-1:0]    in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  block_peak_normalize_dac_requant_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 12 ns clock: low half first, then high half.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the open block and the two registers; when a
  // block closes, every code of that block is appended to pending_codes.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]          gain_limit = bpndr_pkg::MAX_GAIN_RST;
  logic [CFG_W-1:0]          width_reg  = bpndr_pkg::OUT_BITS_RST;
  logic signed [SAMPLE_W-1:0] held_samples [BLOCK_LEN];
  int                        held_count = 0;
  int                        held_peak  = 0;
  dac_word_t                 pending_codes [$];

  int  error_count    = 0;
  int  samples_sent   = 0;
  int  random_samples = 0;
  int  blocks_closed  = 0;
  int  codes_checked  = 0;
  int  settings_used  = 1;
  int  stuck_cycles   = 0;
  // When set, neither the sender nor the receiver inserts idle cycles.
  bit  steady = 1'b0;

  // Scale by the gain, saturate to 16 bits, move into offset binary less
  // 2**(width-1), clamp at zero and keep the top width bits.
  function automatic logic [CODE_W-1:0] requant_code(input int s, input int gain,
                                                      input int width);
    int prod;
    int biased;
    prod = s * gain;
    if (prod > 32767) prod = 32767;
    if (prod < -32768) prod = -32768;
    biased = prod + 32768 - (1 << (width - 1));
    if (biased < 0) biased = 0;
    return CODE_W'((biased >> (16 - width)) & ((1 << width) - 1));
  endfunction

  // Take one accepted sample into the open block; close it on last or when full.
  task automatic collect_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    int sv;
    int mag;
    int cap;
    int gain;
    int width;
    dac_word_t w;
    sv = s;
    mag = (sv < 0) ? -sv : sv;
    held_samples[held_count] = s;
    held_count++;
    if (mag > held_peak) held_peak = mag;
    if (last || held_count == BLOCK_LEN) begin
      cap = (gain_limit == 0) ? 1 : int'(gain_limit);
      if (held_peak == 0) begin
        gain = cap;
      end else begin
        gain = 32768 / held_peak;
        if (gain > cap) gain = cap;
      end
      width = (width_reg < 8) ? 8 : (width_reg > 10) ? 10 : int'(width_reg);
      for (int k = 0; k < held_count; k++) begin
        w.code = requant_code(int'(held_samples[k]), gain, width);
        w.eob  = (k == held_count - 1);
        pending_codes.push_back(w);
      end
      held_count = 0;
      held_peak  = 0;
      blocks_closed++;
    end
  endtask

  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < 12);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers. send_sample leaves in_tvalid high after its request is taken so
  // that back-to-back requests never lower and raise valid in one time step.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    while (take_gap()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    collect_sample(s, last);
  endtask

  // Drop valid, wait until every predicted code has come back, then let the
  // core finish its emit pass before anything else is changed.
  task automatic wait_for_codes();
    in_tvalid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes both registers back to back; only legal while no block is open.
  task automatic set_config(input logic [CFG_W-1:0] gain_cap, input logic [CFG_W-1:0] width);
    cfg_valid <= 1'b1;
    cfg_index <= bpndr_pkg::REG_MAX_GAIN;
    cfg_data  <= gain_cap;
    do @(posedge clk); while (!cfg_ready);
    gain_limit = gain_cap;
    cfg_index <= bpndr_pkg::REG_OUT_BITS;
    cfg_data  <= width;
    do @(posedge clk); while (!cfg_ready);
    width_reg = width;
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Random sample of the given style: silent, full range, or bounded by span; 6% are full-scale extremes.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int style, input int span);
    int r;
    r = $urandom_range(99);
    if (r < 3) return 16'sh8000;
    if (r < 6) return 16'sh7FFF;
    case (style)
      0:       return '0;
      1:       return SAMPLE_W'($urandom_range(16'hFFFF));
      default: return SAMPLE_W'(int'($urandom_range(2 * span)) - span);
    endcase
  endfunction

  // A run of len samples, closed into a block by the core whenever the store fills. The final
  // sample carries last, except that a block filling exactly to capacity may close on its own instead.
  task automatic send_block(input int len);
    int style;
    int span;
    logic last;
    style = $urandom_range(9);
    style = (style == 0) ? 0 : (style < 5) ? 1 : 2;
    span  = 1 << $urandom_range(14);
    for (int k = 0; k < len; k++) begin
      last = 1'b0;
      if (k == len - 1) last = (len % BLOCK_LEN == 0) ? 1'($urandom_range(1)) : 1'b1;
      send_sample(pick_sample(style, span), last);
      random_samples++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and an in-order check of every code.
  // ---------------------------------------------------------------------------
  task automatic check_code();
    dac_word_t w;
    if (pending_codes.size() == 0) begin
      report_mismatch($sformatf("unexpected code tdata=%h tlast=%b", out_tdata, out_tlast));
    end else begin
      w = pending_codes.pop_front();
      codes_checked++;
      if (out_tdata !== {{(OUT_TDATA_W-CODE_W){1'b0}}, w.code})
        report_mismatch($sformatf("code %0d: got %h, wanted %h", codes_checked,
                                  out_tdata, w.code));
      if (out_tlast !== w.eob)
        report_mismatch($sformatf("code %0d: end_of_block got %b, wanted %b",
                                  codes_checked, out_tlast, w.eob));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_code();
    out_tready <= !take_gap();
  end

  // Hang detector: any accepted request on any channel resets the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Timeout: no request accepted for %0d cycles", STUCK_LIMIT);
        $display("block_peak_normalize_dac_requant_core verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values with the edge cases of the gain: a full-scale
  // negative peak, a silent block, a near full-scale pair, a capped gain and
  // a gain just below a power of two.
  task automatic test_reset_defaults();
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32767, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(16'sd300, 1'b0);
    send_sample(-16'sd2000, 1'b0);
    send_sample(16'sd7, 1'b1);
    send_sample(16'sd4096, 1'b0);
    send_sample(-16'sd4097, 1'b1);
    wait_for_codes();
  endtask

  // Register corners: a zero gain limit, the largest limit, widths below and
  // above the legal range, and each legal width. The lone 4096 sample drives
  // the product to exactly +32768, which must saturate.
  task automatic test_register_corners();
    set_config(4'd0, 4'd3);
    send_sample(-16'sd1234, 1'b0);
    send_sample(16'sd2047, 1'b1);
    wait_for_codes();
    set_config(4'd15, 4'd8);
    send_sample(16'sd4096, 1'b1);
    send_sample(-16'sd4096, 1'b0);
    send_sample(16'sd100, 1'b1);
    wait_for_codes();
    set_config(4'd1, 4'd9);
    send_sample(16'sd12345, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    wait_for_codes();
    set_config(4'd15, 4'd15);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b1);
    wait_for_codes();
    set_config(4'd7, 4'd10);
    send_sample(16'sd1000, 1'b0);
    send_sample(-16'sd900, 1'b1);
    wait_for_codes();
  endtask

  // A block that fills to capacity without last closes on its own; the next
  // block must start fresh with its own peak. Both sides run without idle
  // cycles for the whole test.
  task automatic test_block_capacity();
    set_config(bpndr_pkg::MAX_GAIN_RST, bpndr_pkg::OUT_BITS_RST);
    steady = 1'b1;
    for (int k = 0; k < BLOCK_LEN; k++)
      send_sample(SAMPLE_W'(int'($urandom_range(20000)) - 10000), 1'b0);
    send_sample(16'sd50, 1'b0);
    send_sample(-16'sd20, 1'b0);
    send_sample(16'sd3, 1'b1);
    wait_for_codes();
    steady = 1'b0;
  endtask

  // Random phases: each picks a setting (extremes often), sends a few blocks of
  // random length and content, then drains fully before the next setting.
  // The third phase, if the run gets that far, has no idle cycles on either side.
  task automatic test_random_blocks();
    int phase;
    int r;
    int len;
    logic [CFG_W-1:0] g;
    logic [CFG_W-1:0] w;
    phase = 0;
    while (random_samples < RANDOM_ITEMS) begin
      r = $urandom_range(3);
      g = (r == 0) ? 4'd1 : (r == 1) ? 4'd15 : (r == 2) ? 4'd0 : CFG_W'($urandom_range(15));
      r = $urandom_range(4);
      w = (r == 0) ? 4'd8 : (r == 1) ? 4'd9 : (r == 2) ? 4'd10 : CFG_W'($urandom_range(15));
      set_config(g, w);
      steady = (phase == 2);
      for (int b = 0; b < 1 + $urandom_range(2); b++) begin
        r = $urandom_range(99);
        if (r < 15)      len = BLOCK_LEN;
        else if (r < 25) len = BLOCK_LEN + 1 + $urandom_range(35);
        else             len = 1 + $urandom_range(23);
        send_block(len);
        // Now and then hold the sender back until the core has emptied.
        if ($urandom_range(3) == 0) wait_for_codes();
      end
      wait_for_codes();
      steady = 1'b0;
      phase++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_corners();
    test_block_capacity();
    test_random_blocks();

    $display("Sent %0d samples in %0d blocks across %0d register settings;",
             samples_sent, blocks_closed, settings_used);
    $display("compared %0d codes, %0d mismatches.", codes_checked, error_count);
    if (error_count == 0 && pending_codes.size() == 0) begin
      $display("block_peak_normalize_dac_requant_core verification clean");
    end else begin
      if (pending_codes.size() != 0)
        $display("%0d predicted codes never arrived", pending_codes.size());
      $display("block_peak_normalize_dac_requant_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/bpndr_pkg.sv
design/bpndr_mem.sv
design/bpndr_gain_div.sv
design/block_peak_normalize_dac_requant_core.sv
design/bpndr_checker.sv
tb/sv/tb_top.sv
